// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the sample format converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PCMFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcmfc assertion failed");

// Next-cycle implication, disabled during reset
`define PCMFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcmfc assertion failed");

`endif

// ===== rtl/core/pcmfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmfc_pkg
// Types and constants for the PCM sample format converter.
// ----------------------------------------------------------------------------
package pcmfc_pkg;

   // Sample format codes held in the format registers
   typedef enum logic [1:0] {
      FMT_FLOAT = 2'd0,
      FMT_S16   = 2'd1,
      FMT_U16   = 2'd2
   } fmt_type;

   // Register indexes on the configuration port
   localparam logic [1:0] CSR_IN_FORMAT  = 2'd0;
   localparam logic [1:0] CSR_OUT_FORMAT = 2'd1;

   // Reset values of the format registers
   localparam logic [1:0] IN_FORMAT_RST  = 2'd0;
   localparam logic [1:0] OUT_FORMAT_RST = 2'd1;

   // Float to integer scale (32767) and offset-binary bias (32768)
   localparam logic [14:0] F2I_SCALE = 15'd32767;
   localparam logic [15:0] U16_BIAS  = 16'h8000;

   typedef struct packed {
      logic [31:0] in_sample;
      logic        in_last;
   } req_type;

   typedef struct packed {
      logic [31:0] out_sample;
      logic        out_last;
      logic        format_error;
   } rsp_type;

endpackage

// ===== rtl/core/pcmfc_f2i.sv =====
// ----------------------------------------------------------------------------
// pcmfc_f2i
// Single float to signed and offset-binary 16-bit, with exact single
// precision rounding of the scale and the bias add, truncation and saturation.
// ----------------------------------------------------------------------------
module pcmfc_f2i (
   input  logic [31:0] sample,
   output logic [15:0] s16_val,
   output logic [15:0] u16_val
);

   logic        sign;
   logic [7:0]  expo;
   logic [22:0] frac;
   logic        is_nan;
   logic        is_inf;
   logic [38:0] prod;
   logic        prod_hi;
   logic [23:0] kept;
   logic        guard;
   logic        sticky;
   logic [24:0] rnd;
   logic signed [9:0] sh;
   logic [9:0]  nshift;
   logic [24:0] mag;
   logic        big;
   logic signed [9:0] fx_sh;
   logic [9:0]  fx_n;
   logic [25:0] fx_mask;
   logic [27:0] fx_s;
   logic        fx_st;
   logic [28:0] sum_t;
   logic [2:0]  drop;
   logic [24:0] kept2;
   logic        guard2;
   logic        sticky2;
   logic [24:0] rr;
   logic [28:0] wide;
   logic [16:0] ival;

   assign sign   = sample[31];
   assign expo   = sample[30:23];
   assign frac   = sample[22:0];
   assign is_nan = (expo == 8'hFF) && (frac != '0);
   assign is_inf = (expo == 8'hFF) && (frac == '0);

   // Scale by 32767, round to 24 significant bits (nearest even)
   assign prod    = {15'd0, 1'b1, frac} * {24'd0, pcmfc_pkg::F2I_SCALE};
   assign prod_hi = prod[38];

   always_comb begin
      if (prod_hi) begin
         kept   = prod[38:15];
         guard  = prod[14];
         sticky = |prod[13:0];
      end else begin
         kept   = prod[37:14];
         guard  = prod[13];
         sticky = |prod[12:0];
      end
      // subnormals and zero scale to far below one
      if (expo == 8'd0) begin
         rnd = '0;
      end else begin
         rnd = {1'b0, kept} + 25'(guard & (sticky | kept[0]));
      end
      // scaled value is rnd * 2^sh
      sh = $signed({2'b00, expo}) - (prod_hi ? 10'sd135 : 10'sd136);
   end

   // Integer magnitude of the scaled value and range check
   always_comb begin
      nshift = 10'(-sh);
      mag    = '0;
      if (sh[9] && (nshift < 10'd25)) begin
         mag = rnd >> nshift[4:0];
      end
      big = is_inf || !sh[9] || (mag[24:15] != '0);
   end

   // Signed result
   always_comb begin
      if (is_nan) begin
         s16_val = '0;
      end else if (big) begin
         s16_val = sign ? 16'h8000 : 16'h7FFF;
      end else if (sign) begin
         s16_val = ~mag[15:0] + 16'd1;
      end else begin
         s16_val = mag[15:0];
      end
   end

   // Scaled value as fixed point with 12 fraction bits plus a sticky bit
   always_comb begin
      fx_sh   = sh + 10'sd12;
      fx_n    = 10'(-fx_sh);
      fx_mask = '0;
      fx_s    = '0;
      fx_st   = 1'b0;
      if (!fx_sh[9]) begin
         fx_s = 28'(rnd) << fx_sh[1:0];
      end else if (fx_n >= 10'd26) begin
         fx_st = |rnd;
      end else begin
         fx_mask = (26'd1 << fx_n[4:0]) - 26'd1;
         fx_s    = 28'(rnd >> fx_n[4:0]);
         fx_st   = |({1'b0, rnd} & fx_mask);
      end
   end

   // Add the 32768 bias and round the sum to single precision
   always_comb begin
      if (sign) begin
         sum_t = 29'h0800_0000 - 29'(fx_s) - 29'(fx_st);
      end else begin
         sum_t = 29'h0800_0000 + 29'(fx_s);
      end
      if (sum_t[27]) begin
         drop = 3'd4;
      end else if (sum_t[26]) begin
         drop = 3'd3;
      end else if (sum_t[25]) begin
         drop = 3'd2;
      end else if (sum_t[24]) begin
         drop = 3'd1;
      end else begin
         drop = 3'd0;
      end
      kept2 = 25'(sum_t >> drop);
      unique case (drop)
         3'd1: begin
            guard2  = sum_t[0];
            sticky2 = 1'b0;
         end
         3'd2: begin
            guard2  = sum_t[1];
            sticky2 = sum_t[0];
         end
         3'd3: begin
            guard2  = sum_t[2];
            sticky2 = |sum_t[1:0];
         end
         3'd4: begin
            guard2  = sum_t[3];
            sticky2 = |sum_t[2:0];
         end
         default: begin
            guard2  = 1'b0;
            sticky2 = 1'b0;
         end
      endcase
      rr   = kept2 + 25'(guard2 & (sticky2 | fx_st | kept2[0]));
      wide = 29'(rr) << drop;
      ival = wide[28:12];
   end

   // Offset-binary result
   always_comb begin
      if (is_nan) begin
         u16_val = '0;
      end else if (big) begin
         u16_val = sign ? 16'h0000 : 16'hFFFF;
      end else if (ival[16]) begin
         u16_val = 16'hFFFF;
      end else begin
         u16_val = ival[15:0];
      end
   end

endmodule

// ===== rtl/core/pcmfc_i2f.sv =====
// ----------------------------------------------------------------------------
// pcmfc_i2f
// Signed 16-bit to single float, value divided by 32768 (always exact).
// ----------------------------------------------------------------------------
module pcmfc_i2f (
   input  logic [15:0] s16_in,
   output logic [31:0] float_out
);

   logic        neg;
   logic [15:0] mag;
   logic [3:0]  lead;
   logic [23:0] norm;
   logic [7:0]  expo;

   // Magnitude and leading one position
   always_comb begin
      neg  = s16_in[15];
      mag  = neg ? (~s16_in + 16'd1) : s16_in;
      lead = '0;
      for (int i = 0; i < 16; i++) begin
         if (mag[i]) begin
            lead = 4'(i);
         end
      end
      norm = 24'(mag) << (5'd23 - {1'b0, lead});
      expo = 8'd112 + {4'd0, lead};
   end

   // Pack; zero gives positive zero
   always_comb begin
      if (mag == '0) begin
         float_out = '0;
      end else begin
         float_out = {neg, expo, norm[22:0]};
      end
   end

endmodule

// ===== rtl/core/pcm_sample_format_converter.sv =====
// ----------------------------------------------------------------------------
// pcm_sample_format_converter
// Converts one PCM sample per item between float32, signed 16-bit and
// offset-binary 16-bit, selected by the in and out format registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | req_data (in_sample, in_last)
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_data (out_sample, out_last,
//          |           |                    |           format_error)
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One item per cycle sustained while rsp_stall is low; the path is an input
// register, then a result register, with the conversion logic between them.
// Reset is synchronous: the pipeline empties and the formats return to
// float32 in, signed 16-bit out.
// A stalled result holds the result register and a full input register; the
// input side stalls only when both stages are full.
// csr_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcm_sample_format_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pcmfc_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pcmfc_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [1:0]           csr_data
);

   logic                 s1_valid_ff, s1_valid_in;
   pcmfc_pkg::req_type   s1_data_ff, s1_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pcmfc_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic [1:0]           in_fmt_ff, in_fmt_in;
   logic [1:0]           out_fmt_ff, out_fmt_in;
   logic                 advance;
   logic                 s1_load;
   logic [15:0]          f2i_s16;
   logic [15:0]          f2i_u16;
   logic [15:0]          i2f_src;
   logic [31:0]          i2f_float;
   logic [31:0]          res;
   logic                 err;

   // Handshake
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || advance;
   assign req_stall = !s1_load;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Format registers
   always_comb begin
      in_fmt_in  = in_fmt_ff;
      out_fmt_in = out_fmt_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == pcmfc_pkg::CSR_IN_FORMAT) begin
            in_fmt_in = csr_data;
         end else if (csr_index == pcmfc_pkg::CSR_OUT_FORMAT) begin
            out_fmt_in = csr_data;
         end
      end
   end

   // Conversion units
   assign i2f_src = (in_fmt_ff == pcmfc_pkg::FMT_U16) ?
                    (s1_data_ff.in_sample[15:0] ^ pcmfc_pkg::U16_BIAS) :
                    s1_data_ff.in_sample[15:0];

   pcmfc_f2i u_f2i (
      .sample  (s1_data_ff.in_sample),
      .s16_val (f2i_s16),
      .u16_val (f2i_u16)
   );

   pcmfc_i2f u_i2f (
      .s16_in    (i2f_src),
      .float_out (i2f_float)
   );

   // Result selection by format pair
   always_comb begin
      res = '0;
      err = 1'b0;
      if (in_fmt_ff == pcmfc_pkg::FMT_FLOAT && out_fmt_ff == pcmfc_pkg::FMT_S16) begin
         res = {16'd0, f2i_s16};
      end else if (in_fmt_ff == pcmfc_pkg::FMT_FLOAT &&
                   out_fmt_ff == pcmfc_pkg::FMT_U16) begin
         res = {16'd0, f2i_u16};
      end else if ((in_fmt_ff == pcmfc_pkg::FMT_S16 || in_fmt_ff == pcmfc_pkg::FMT_U16) &&
                   out_fmt_ff == pcmfc_pkg::FMT_FLOAT) begin
         res = i2f_float;
      end else if ((in_fmt_ff == pcmfc_pkg::FMT_S16 && out_fmt_ff == pcmfc_pkg::FMT_U16) ||
                   (in_fmt_ff == pcmfc_pkg::FMT_U16 && out_fmt_ff == pcmfc_pkg::FMT_S16)) begin
         res = {16'd0, s1_data_ff.in_sample[15:0] ^ pcmfc_pkg::U16_BIAS};
      end else begin
         err = 1'b1;
      end
   end

   // Pipeline next state
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in             = s1_valid_ff;
         rsp_data_in.out_sample   = res;
         rsp_data_in.out_last     = s1_data_ff.in_last;
         rsp_data_in.format_error = err;
      end
      if (s1_load) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         in_fmt_ff    <= pcmfc_pkg::IN_FORMAT_RST;
         out_fmt_ff   <= pcmfc_pkg::OUT_FORMAT_RST;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         in_fmt_ff    <= in_fmt_in;
         out_fmt_ff   <= out_fmt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   `PCMFC_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid_ff && rsp_data_ff.format_error, rsp_data_ff.out_sample == 32'd0)
   `PCMFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)
   `PCMFC_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCM sample format converter. Items go through
// the request channel under random idle and stall bursts; an integer-only
// model of the single-precision arithmetic predicts each result, which is
// checked field by field against the response channel in order.
// ----------------------------------------------------------------------------
module tb;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   pcmfc_pkg::req_type  req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   pcmfc_pkg::rsp_type  rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = pcmfc_pkg::CSR_IN_FORMAT;
   logic [1:0]          csr_data = '0;

   // bench copy of the format registers
   logic [1:0]  src_fmt = pcmfc_pkg::IN_FORMAT_RST;
   logic [1:0]  dst_fmt = pcmfc_pkg::OUT_FORMAT_RST;

   pcmfc_pkg::rsp_type  pending_samples[$];
   int          mismatches = 0;
   bit          quiet = 1'b0;

   pcm_sample_format_converter dut (.*);

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Arithmetic helpers: exact integers standing in for single precision
   // ---------------------------------------------------------------------------

   // round a magnitude to a 24-bit significand, nearest even
   function automatic void round_sig(input logic [127:0] mag, input int ex,
                                     output logic [127:0] rmag, output int rex);
      int          len;
      int          sh;
      logic [127:0] rem;
      logic [127:0] half;
      len = 0;
      for (int i = 127; i >= 0; i--)
         if (mag[i] && len == 0) len = i + 1;
      rmag = mag;
      rex = ex;
      if (len > 24) begin
         sh = len - 24;
         rmag = mag >> sh;
         rem = mag & ((128'(1) << sh) - 1);
         half = 128'(1) << (sh - 1);
         if (rem > half || (rem == half && rmag[0])) rmag = rmag + 1;
         rex = ex + sh;
      end
   endfunction

   function automatic logic [127:0] whole_part(logic [127:0] mag, int ex);
      if (ex >= 0) return mag << ex;
      if (-ex >= 128) return '0;
      return mag >> (-ex);
   endfunction

   // float to 16-bit: scale by 32767, optional bias, truncate and saturate
   function automatic logic [15:0] float_to_pcm(logic [31:0] b, bit biased);
      logic         sgn;
      logic [7:0]   e;
      logic [127:0] mant;
      logic [127:0] r;
      logic [127:0] t;
      logic [127:0] a;
      logic [127:0] c;
      int           ex;
      int           e2;
      int           eb;
      logic [16:0]  sv;
      sgn = b[31];
      e = b[30:23];
      if (e == 8'hFF && b[22:0] != 0) return 16'h0000;
      if (e == 8'hFF) begin
         if (biased) return sgn ? 16'h0000 : 16'hFFFF;
         return sgn ? 16'h8000 : 16'h7FFF;
      end
      mant = (e != 0) ? {104'd0, 1'b1, b[22:0]} : {105'd0, b[22:0]};
      ex = (e != 0) ? int'(e) - 150 : -149;
      if (mant == 0) return biased ? pcmfc_pkg::U16_BIAS : 16'h0000;
      round_sig(mant * 32767, ex, r, e2);
      if (!biased) begin
         if (e2 > 20) return sgn ? 16'h8000 : 16'h7FFF;
         t = whole_part(r, e2);
         if (!sgn && t >= 32768) return 16'h7FFF;
         if (sgn && t >= 32769) return 16'h8000;
         sv = sgn ? -t[16:0] : t[16:0];
         return sv[15:0];
      end
      if (e2 > 20 || whole_part(r, e2) >= (1 << 17)) return sgn ? 16'h0000 : 16'hFFFF;
      if (e2 < -60) return pcmfc_pkg::U16_BIAS;
      // exact sum with the bias on a common exponent, then one rounding
      eb = (e2 < 0) ? e2 : 0;
      a = 128'(32768) << (-eb);
      c = r << (e2 - eb);
      if (sgn && c > a) return 16'h0000;
      round_sig(sgn ? a - c : a + c, eb, r, e2);
      t = whole_part(r, e2);
      if (t >= 65536) return 16'hFFFF;
      return t[15:0];
   endfunction

   // 16-bit signed value over 32768 is always exact in single precision
   function automatic logic [31:0] pcm_to_float(logic [15:0] s);
      logic        sgn;
      logic [15:0] mag;
      int          p;
      logic [31:0] m;
      if (s == 0) return 32'h0;
      sgn = s[15];
      mag = sgn ? -s : s;
      p = 0;
      for (int i = 0; i < 16; i++)
         if (mag[i]) p = i;
      m = 32'(mag) << (23 - p);
      return {sgn, 8'(127 + p - 15), m[22:0]};
   endfunction

   function automatic pcmfc_pkg::rsp_type convert_sample(pcmfc_pkg::req_type it);
      pcmfc_pkg::rsp_type o;
      o = '0;
      o.out_last = it.in_last;
      if (src_fmt == pcmfc_pkg::FMT_FLOAT && dst_fmt == pcmfc_pkg::FMT_S16)
         o.out_sample = {16'h0, float_to_pcm(it.in_sample, 1'b0)};
      else if (src_fmt == pcmfc_pkg::FMT_FLOAT && dst_fmt == pcmfc_pkg::FMT_U16)
         o.out_sample = {16'h0, float_to_pcm(it.in_sample, 1'b1)};
      else if (src_fmt == pcmfc_pkg::FMT_S16 && dst_fmt == pcmfc_pkg::FMT_FLOAT)
         o.out_sample = pcm_to_float(it.in_sample[15:0]);
      else if (src_fmt == pcmfc_pkg::FMT_U16 && dst_fmt == pcmfc_pkg::FMT_FLOAT)
         o.out_sample = pcm_to_float(it.in_sample[15:0] ^ pcmfc_pkg::U16_BIAS);
      else if ((src_fmt == pcmfc_pkg::FMT_S16 && dst_fmt == pcmfc_pkg::FMT_U16) ||
               (src_fmt == pcmfc_pkg::FMT_U16 && dst_fmt == pcmfc_pkg::FMT_S16))
         o.out_sample = {16'h0, it.in_sample[15:0] ^ pcmfc_pkg::U16_BIAS};
      else
         o.format_error = 1'b1;
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   task automatic send_sample(input logic [31:0] smp, input logic last);
      pcmfc_pkg::req_type it;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      it.in_sample = smp;
      it.in_last = last;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      pending_samples.push_back(convert_sample(it));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_formats(input logic [1:0] src, input logic [1:0] dst);
      drain();
      csr_valid <= 1'b1;
      csr_index <= pcmfc_pkg::CSR_IN_FORMAT;
      csr_data <= src;
      do @(posedge clock); while (!csr_ready);
      csr_index <= pcmfc_pkg::CSR_OUT_FORMAT;
      csr_data <= dst;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      src_fmt = src;
      dst_fmt = dst;
      @(posedge clock);
   endtask

   // result side stall bursts
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) hold--;
         else if (!quiet && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(1, 19);
         end
         rsp_stall <= (hold > 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      pcmfc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", rsp_data);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_data.out_sample !== want.out_sample ||
                rsp_data.out_last !== want.out_last ||
                rsp_data.format_error !== want.format_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: sample %h/%h last %b/%b err %b/%b (exp/act)",
                           want.out_sample, rsp_data.out_sample,
                           want.out_last, rsp_data.out_last,
                           want.format_error, rsp_data.format_error);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   localparam logic [31:0] FLOAT_EDGES[16] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
      32'h3F00_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0000,
      32'hFF80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0001,
      32'h3F7F_FFFF, 32'hBF80_0001, 32'h3F7F_FF00, 32'hB800_0000};

   localparam logic [31:0] PCM_EDGES[8] = '{
      32'h0000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'hABCD_0000, 32'h5555_8001, 32'h0000_7FFE};

   // reset formats: float in, signed out
   task automatic test_reset_formats;
      foreach (FLOAT_EDGES[i]) send_sample(FLOAT_EDGES[i], i[0]);
   endtask

   task automatic test_float_to_offset;
      set_formats(pcmfc_pkg::FMT_FLOAT, pcmfc_pkg::FMT_U16);
      foreach (FLOAT_EDGES[i]) send_sample(FLOAT_EDGES[i], i[1]);
   endtask

   task automatic test_pcm_to_float;
      set_formats(pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_FLOAT);
      foreach (PCM_EDGES[i]) send_sample(PCM_EDGES[i], i[0]);
      // hold off until the pipeline is empty, then carry on
      drain();
      set_formats(pcmfc_pkg::FMT_U16, pcmfc_pkg::FMT_FLOAT);
      foreach (PCM_EDGES[i]) send_sample(PCM_EDGES[i], ~i[0]);
   endtask

   task automatic test_signed_swap;
      set_formats(pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_U16);
      foreach (PCM_EDGES[i]) send_sample(PCM_EDGES[i], i[0]);
      set_formats(pcmfc_pkg::FMT_U16, pcmfc_pkg::FMT_S16);
      foreach (PCM_EDGES[i]) send_sample(PCM_EDGES[i], i[1]);
   endtask

   // identical pairs and the unused code 3 give the error flag
   task automatic test_bad_pairs;
      set_formats(pcmfc_pkg::FMT_FLOAT, pcmfc_pkg::FMT_FLOAT);
      send_sample(32'h3F80_0000, 1'b1);
      set_formats(pcmfc_pkg::FMT_S16, pcmfc_pkg::FMT_S16);
      send_sample(32'hFFFF_FFFF, 1'b0);
      set_formats(2'd3, pcmfc_pkg::FMT_S16);
      send_sample(32'h1234_5678, 1'b1);
      set_formats(pcmfc_pkg::FMT_FLOAT, 2'd3);
      send_sample(32'h8000_0000, 1'b1);
   endtask

   function automatic logic [31:0] random_sample;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return {1'($urandom()), 8'($urandom_range(100, 127)), 23'($urandom())};
         2: return {1'($urandom()), 8'($urandom_range(126, 127)), 23'($urandom())};
         default: return {16'($urandom()), 16'($urandom())};
      endcase
   endfunction

   task automatic test_random_stream;
      for (int ph = 0; ph < 16; ph++) begin
         if (ph == 15) quiet = 1'b1;
         if (ph < 12 || ph == 15)
            set_formats(2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)));
         else
            set_formats(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
         repeat (100) send_sample(random_sample(), 1'($urandom()));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_formats();
      test_float_to_offset();
      test_pcm_to_float();
      test_signed_swap();
      test_bad_pairs();
      test_random_stream();
      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_samples.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
